### rtl/ovd_pkg.sv
// Shared types and constants for the sprite-table and video-memory DMA controller.
// Used by the front end, the command queue, the back end and the top level.
package ovd_pkg;

	// Operation codes of an incoming beat.
	localparam logic [2:0] OP_REG_WRITE     = 3'd0;
	localparam logic [2:0] OP_REG_READ      = 3'd1;
	localparam logic [2:0] OP_TICK          = 3'd2;
	localparam logic [2:0] OP_HBLANK_NOTIFY = 3'd3;
	localparam logic [2:0] OP_HBLANK_BLOCK  = 3'd4;
	localparam logic [2:0] OP_CLEAR_PENDING = 3'd5;

	// Register indexes; the four address bytes occupy a contiguous range.
	localparam logic [2:0] REG_SPRITE_PAGE = 3'd0;
	localparam logic [2:0] REG_ADDR_FIRST  = 3'd1;
	localparam logic [2:0] REG_ADDR_LAST   = 3'd4;
	localparam logic [2:0] REG_VIDEO_LEN   = 3'd5;

	// Copy targets.
	localparam logic [1:0] TGT_NONE   = 2'd0;
	localparam logic [1:0] TGT_SPRITE = 2'd1;
	localparam logic [1:0] TGT_VIDEO  = 2'd2;

	// Classified command kinds passed from front to back.
	localparam logic [3:0] CMD_NOP          = 4'd0;
	localparam logic [3:0] CMD_SPRITE_START = 4'd1;
	localparam logic [3:0] CMD_ADDR_WRITE   = 4'd2;
	localparam logic [3:0] CMD_LEN_WRITE    = 4'd3;
	localparam logic [3:0] CMD_READ         = 4'd4;
	localparam logic [3:0] CMD_TICK         = 4'd5;
	localparam logic [3:0] CMD_NOTIFY       = 4'd6;
	localparam logic [3:0] CMD_BLOCK        = 4'd7;
	localparam logic [3:0] CMD_CLEAR        = 4'd8;

	// Fixed constants of the transfer engines.
	localparam logic [7:0]  MAX_SPRITE_PAGE = 8'hDF;
	localparam logic [15:0] VIDEO_BASE      = 16'h8000;
	localparam logic [15:0] VIDEO_WRAP      = 16'h1FFF;
	localparam logic [7:0]  IDLE_STATUS     = 8'hFF;
	localparam logic [7:0]  UNUSED_READ     = 8'hFF;
	localparam logic [15:0] BLOCK_BYTES     = 16'd16;

	typedef struct packed {
		logic [2:0] operation;
		logic [2:0] reg_index;
		logic [7:0] write_data;
		logic [7:0] tick_cycles;
	} req_item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [1:0]  copy_target;
		logic [15:0] copy_source;
		logic [15:0] copy_destination;
		logic [11:0] copy_length;
		logic        cpu_blocked;
		logic        block_pending;
		logic        video_dma_busy;
	} rsp_item_t;

	// Command word: data carries the written byte or the granted slot count.
	typedef struct packed {
		logic [3:0] kind;
		logic [2:0] reg_index;
		logic [7:0] data;
	} cmd_t;

endpackage

### rtl/ovd_front.sv
// Front end: accepts request beats and classifies them into commands.
// Depends on ovd_pkg; feeds ovd_queue.
module ovd_front
	import ovd_pkg::*;
(
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	input  logic      queue_full,
	output logic      push,
	output cmd_t      cmd
);

	// A beat is taken whenever the queue has room.
	assign req_ready = !queue_full;
	assign push      = req_valid && !queue_full;

	// Classify the operation; writes that have no effect become no-ops.
	always_comb begin
		cmd.reg_index = req.reg_index;
		cmd.data      = req.write_data;
		cmd.kind      = CMD_NOP;
		case (req.operation)
			OP_REG_WRITE: begin
				if (req.reg_index == REG_SPRITE_PAGE) begin
					if (req.write_data <= MAX_SPRITE_PAGE) begin
						cmd.kind = CMD_SPRITE_START;
					end
				end else if (req.reg_index inside {[REG_ADDR_FIRST:REG_ADDR_LAST]}) begin
					cmd.kind = CMD_ADDR_WRITE;
				end else if (req.reg_index == REG_VIDEO_LEN) begin
					cmd.kind = CMD_LEN_WRITE;
				end
			end
			OP_REG_READ: begin
				cmd.kind = CMD_READ;
			end
			OP_TICK: begin
				cmd.kind = CMD_TICK;
				cmd.data = req.tick_cycles;
			end
			OP_HBLANK_NOTIFY: begin
				cmd.kind = CMD_NOTIFY;
			end
			OP_HBLANK_BLOCK: begin
				cmd.kind = CMD_BLOCK;
			end
			OP_CLEAR_PENDING: begin
				cmd.kind = CMD_CLEAR;
			end
			default: begin
				cmd.kind = CMD_NOP;
			end
		endcase
	end

endmodule

### rtl/ovd_queue.sv
// Short command queue between the front end and the back end.
// Depends on ovd_pkg for the command type.
module ovd_queue
	import ovd_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	cmd_t             entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/ovd_back.sv
// Back end: holds both engines' state, executes one command per cycle while the output
// register is free and registers the response beat. Depends on ovd_pkg; fed by ovd_queue.
module ovd_back
	import ovd_pkg::*;
#(
	parameter int SPRITE_TABLE_BYTES = 160
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  cmd_t      head_cmd,
	output logic      pop,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	localparam logic [8:0] SPR_LEN = 9'(SPRITE_TABLE_BYTES);

	logic        sprite_active_q;
	logic [7:0]  sprite_page_q;
	logic [7:0]  sprite_position_q;
	logic        video_active_q;
	logic [15:0] video_source_q;
	logic [15:0] video_destination_q;
	logic [6:0]  blocks_left_q;
	logic [7:0]  address_bytes_q [4];
	logic [7:0]  length_status_q;
	logic        hblank_request_q;
	logic        rsp_valid_q;
	rsp_item_t   rsp_q;

	logic        sprite_active_d;
	logic [7:0]  sprite_page_d;
	logic [7:0]  sprite_position_d;
	logic        video_active_d;
	logic [15:0] video_source_d;
	logic [15:0] video_destination_d;
	logic [6:0]  blocks_left_d;
	logic [7:0]  length_status_d;
	logic        hblank_request_d;
	rsp_item_t   rsp_d;

	logic [1:0]  addr_sel;
	logic [15:0] reg_source;
	logic [15:0] reg_destination;
	logic [8:0]  spr_left;
	logic [8:0]  spr_count;
	logic [8:0]  spr_next;
	logic [15:0] dst_step;

	// The output register frees up when it is empty or being taken.
	assign pop       = head_valid && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign addr_sel        = 2'(head_cmd.reg_index - REG_ADDR_FIRST);
	assign reg_source      = {address_bytes_q[0], address_bytes_q[1][7:4], 4'b0};
	assign reg_destination = VIDEO_BASE | {3'b0, address_bytes_q[2][4:0],
		address_bytes_q[3][7:4], 4'b0};

	// Sprite tick arithmetic: slots granted against bytes remaining.
	assign spr_left  = ({1'b0, sprite_position_q} < SPR_LEN) ?
		(SPR_LEN - {1'b0, sprite_position_q}) : 9'd0;
	assign spr_count = ({1'b0, head_cmd.data} < spr_left) ? {1'b0, head_cmd.data} : spr_left;
	assign spr_next  = {1'b0, sprite_position_q} + spr_count;
	assign dst_step  = video_destination_q + BLOCK_BYTES;

	// Execute the command at the queue head.
	always_comb begin
		sprite_active_d     = sprite_active_q;
		sprite_page_d       = sprite_page_q;
		sprite_position_d   = sprite_position_q;
		video_active_d      = video_active_q;
		video_source_d      = video_source_q;
		video_destination_d = video_destination_q;
		blocks_left_d       = blocks_left_q;
		length_status_d     = length_status_q;
		hblank_request_d    = hblank_request_q;
		rsp_d               = '0;
		case (head_cmd.kind)
			CMD_SPRITE_START: begin
				sprite_page_d     = head_cmd.data;
				sprite_position_d = '0;
				sprite_active_d   = 1'b1;
			end
			CMD_LEN_WRITE: begin
				if (!head_cmd.data[7] && video_active_q) begin
					video_active_d  = 1'b0;
					length_status_d = {1'b1, blocks_left_q};
				end else if (!head_cmd.data[7]) begin
					rsp_d.copy_target      = TGT_VIDEO;
					rsp_d.copy_source      = reg_source;
					rsp_d.copy_destination = reg_destination;
					rsp_d.copy_length      = {8'({1'b0, head_cmd.data[6:0]} + 8'd1), 4'b0};
					length_status_d        = IDLE_STATUS;
				end else begin
					video_source_d      = reg_source;
					video_destination_d = reg_destination;
					blocks_left_d       = head_cmd.data[6:0];
					video_active_d      = 1'b1;
					length_status_d     = {1'b0, head_cmd.data[6:0]};
				end
			end
			CMD_READ: begin
				if (head_cmd.reg_index inside {[REG_ADDR_FIRST:REG_ADDR_LAST]}) begin
					rsp_d.read_data = address_bytes_q[addr_sel];
				end else if (head_cmd.reg_index == REG_VIDEO_LEN) begin
					rsp_d.read_data = length_status_q;
				end else begin
					rsp_d.read_data = UNUSED_READ;
				end
			end
			CMD_TICK: begin
				if (sprite_active_q) begin
					if (spr_count != '0) begin
						rsp_d.copy_target      = TGT_SPRITE;
						rsp_d.copy_source      = {sprite_page_q, sprite_position_q};
						rsp_d.copy_destination = {8'b0, sprite_position_q};
						rsp_d.copy_length      = {3'b0, spr_count};
					end
					if (spr_next >= SPR_LEN) begin
						sprite_active_d   = 1'b0;
						sprite_position_d = '0;
					end else begin
						sprite_position_d = spr_next[7:0];
					end
				end
			end
			CMD_NOTIFY: begin
				hblank_request_d = 1'b1;
			end
			CMD_BLOCK: begin
				if (video_active_q) begin
					rsp_d.copy_target      = TGT_VIDEO;
					rsp_d.copy_source      = video_source_q;
					rsp_d.copy_destination = video_destination_q;
					rsp_d.copy_length      = 12'(BLOCK_BYTES);
					video_source_d         = video_source_q + BLOCK_BYTES;
					video_destination_d    = VIDEO_BASE | (dst_step & VIDEO_WRAP);
					if (blocks_left_q == '0) begin
						video_active_d  = 1'b0;
						length_status_d = IDLE_STATUS;
					end else begin
						blocks_left_d   = blocks_left_q - 7'd1;
						length_status_d = {1'b0, blocks_left_q - 7'd1};
					end
				end
			end
			CMD_CLEAR: begin
				hblank_request_d = 1'b0;
			end
			default: begin
				rsp_d = '0;
			end
		endcase
		rsp_d.cpu_blocked    = sprite_active_d;
		rsp_d.block_pending  = hblank_request_d;
		rsp_d.video_dma_busy = video_active_d;
	end

	// Engine state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sprite_active_q     <= 1'b0;
			sprite_page_q       <= '0;
			sprite_position_q   <= '0;
			video_active_q      <= 1'b0;
			video_source_q      <= '0;
			video_destination_q <= '0;
			blocks_left_q       <= '0;
			address_bytes_q     <= '{default: 8'hFF};
			length_status_q     <= IDLE_STATUS;
			hblank_request_q    <= 1'b0;
		end else if (pop) begin
			sprite_active_q     <= sprite_active_d;
			sprite_page_q       <= sprite_page_d;
			sprite_position_q   <= sprite_position_d;
			video_active_q      <= video_active_d;
			video_source_q      <= video_source_d;
			video_destination_q <= video_destination_d;
			blocks_left_q       <= blocks_left_d;
			length_status_q     <= length_status_d;
			hblank_request_q    <= hblank_request_d;
			if (head_cmd.kind == CMD_ADDR_WRITE) begin
				address_bytes_q[addr_sel] <= head_cmd.data;
			end
		end
	end

	// Response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (pop) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

### rtl/oam_and_vram_dma_controller.sv
// Top level of the sprite-table and video-memory DMA controller.
// Depends on ovd_pkg, ovd_front, ovd_queue and ovd_back.
//
// Each request beat (register write, register read, tick, hblank notify, hblank block or
// clear pending) yields exactly one response beat carrying the read byte, a copy descriptor
// (target, source, destination, length) and the engine status flags after the request.
// The block sustains one request per clock cycle while the response side is ready: the
// back end executes one command per cycle against the engine state, which is the loop
// that sets this rate. An accepted request is written into the queue; the back end then
// executes it from the queue head into the output register, which presents the response
// beat. The queue of QUEUE_DEPTH entries lets requests keep flowing while a response
// waits to be taken; requests stall only when the queue is full.
module oam_and_vram_dma_controller
	import ovd_pkg::*;
#(
	parameter int SPRITE_TABLE_BYTES = 160,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	logic push;
	logic pop;
	logic queue_full;
	logic head_valid;
	cmd_t push_cmd;
	cmd_t head_cmd;

	// Classify incoming beats.
	ovd_front u_front (
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.queue_full (queue_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	// Buffer commands between the two sides.
	ovd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// Execute commands and produce responses.
	ovd_back #(
		.SPRITE_TABLE_BYTES (SPRITE_TABLE_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule
